### sv/rrlb_pkg.sv
`default_nettype none
package rrlb_pkg;
    localparam int DEF_CAPACITY = 4096;
    typedef enum logic [2:0] {
        ACT_CREATE = 3'd0, ACT_EXTEND = 3'd1, ACT_WRITE = 3'd2, ACT_REWIND = 3'd3,
        ACT_NEXT = 3'd4, ACT_READ = 3'd5, ACT_TRUNC = 3'd6, ACT_NONE = 3'd7
    } t_action;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;
    localparam logic [1:0] ST_IGN = 2'd3;
endpackage
`default_nettype wire

### sv/record_ring_log_buffer.sv
`default_nettype none
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   action[2:0] length[14:3] data_byte[22:15], pad to 24   -
// m_axis    out  status[1:0] entry_serial[33:2] entry_size[45:34]
//                read_byte[53:46] last_byte[54] entry_count[65:55]
//                payload_bytes[77:66] evicted_count[88:78], pad to 96   -
// Next record reads four header bytes on the single memory port; create and
// extend read the header of each record they evict; a dropped create or
// extend skips the header write. A held output delays the next accept.
// Reset clears the state, output valid and ring bookkeeping registers; ring memory is undefined until written.
// Input stalls while a request is in work or a result is held on the output.
module record_ring_log_buffer
    import rrlb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // action, length, data_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata    // status, serial, size, byte, last, count, payload, evicted
);
    // ring size, a power of two; field widths follow from it
    localparam int CAPACITY = DEF_CAPACITY;
    localparam int AW = $clog2(CAPACITY);
    localparam int OW = AW + 1;
    localparam logic [OW-1:0] CAP = OW'(CAPACITY);
    localparam logic [31:0] CAPM4 = 32'(CAPACITY - 4);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_EVRD, S_EVCHK, S_CRCHK, S_CRWR, S_EXRD, S_EXCHK,
        S_EXWR, S_ITRD, S_ITFIN, S_RDWAIT, S_OUT
    } t_state;

    logic [7:0] mem [CAPACITY];
    logic [AW-1:0] r_maddr;
    logic [7:0] r_mq;
    logic r_mwe;
    logic n_mwe;
    logic [7:0] r_mwd;

    t_state r_state;
    logic [2:0] r_act;
    logic [11:0] r_len;
    logic [7:0] r_dbyte;
    logic [OW-1:0] r_occ, r_pend, r_irem;
    logic [AW-1:0] r_start, r_newest, r_wofs, r_inext, r_iend, r_iofs;
    logic [31:0] r_fser, r_iser, r_hdr;
    logic [31:0] r_xhdr;  // grown newest header, kept across evictions
    logic [10:0] r_cnt, r_evc;
    logic r_istart;
    logic [2:0] r_k;      // header byte phase
    logic r_rdp;          // read pending
    logic [1:0] r_st;
    logic [7:0] r_rb;
    logic r_last;

    // memory port: one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (r_mwe) mem[r_maddr] <= r_mwd;
        r_mq <= mem[r_maddr];
    end

    // write strobe: payload byte write and header byte writes
    assign n_mwe = (r_state == S_DISP && r_act == ACT_WRITE && r_pend != '0) ||
                   r_state == S_CRWR || r_state == S_EXWR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mwe <= 1'b0;
        else r_mwe <= n_mwe;
    end

    function automatic logic [AW-1:0] wr(input logic [31:0] a);
        return a[AW-1:0];
    endfunction

    logic [31:0] occ32, need32;
    assign occ32 = 32'(r_occ);
    assign need32 = occ32 + 32'(r_len) + ((r_act == ACT_CREATE) ? 32'd4 : 32'd0);
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);

    logic [31:0] pay;
    always_comb begin
        pay = (occ32 >= {19'd0, r_cnt, 2'b00}) ? occ32 - {19'd0, r_cnt, 2'b00} : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; m_axis_tvalid <= 1'b0;
            r_occ <= '0; r_start <= '0; r_newest <= '0; r_fser <= '0; r_cnt <= '0;
            r_wofs <= '0; r_pend <= '0; r_istart <= 1'b0; r_inext <= '0; r_iend <= '0;
            r_iser <= '0; r_iofs <= '0; r_irem <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_act <= s_axis_tdata[2:0]; r_len <= s_axis_tdata[14:3];
                    r_dbyte <= s_axis_tdata[22:15];
                    r_st <= ST_OK; r_rb <= '0; r_last <= 1'b0; r_evc <= '0;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_k <= '0; r_hdr <= '0; r_rdp <= 1'b0;
                    case (r_act)
                        ACT_CREATE: r_state <= S_CRCHK;
                        ACT_EXTEND: begin
                            if (r_occ == '0) begin
                                r_st <= ST_END; r_state <= S_OUT;
                            end else if (r_len != '0) begin
                                r_maddr <= r_newest; r_state <= S_EXRD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        ACT_WRITE: begin
                            if (r_pend == '0) r_st <= ST_IGN;
                            else begin
                                r_maddr <= r_wofs; r_mwd <= r_dbyte;
                                r_wofs <= wr(32'(r_wofs) + 32'd1);
                                r_pend <= r_pend - OW'(1);
                            end
                            r_state <= S_OUT;
                        end
                        ACT_REWIND: begin
                            r_istart <= 1'b0; r_state <= S_OUT;
                        end
                        ACT_NEXT: begin
                            if (r_occ == '0) begin
                                r_st <= ST_END; r_state <= S_OUT;
                            end else if (!r_istart) begin
                                r_inext <= r_start; r_iend <= wr(32'(r_start) + occ32);
                                r_istart <= 1'b1; r_iser <= r_fser;
                                r_maddr <= r_start; r_state <= S_ITRD;
                            end else if (r_inext == r_iend) begin
                                r_st <= ST_END; r_state <= S_OUT;
                            end else begin
                                r_iser <= r_iser + 32'd1;
                                r_maddr <= r_inext; r_state <= S_ITRD;
                            end
                        end
                        ACT_READ: begin
                            if (r_irem == '0) begin
                                r_st <= ST_END; r_state <= S_OUT;
                            end else begin
                                r_maddr <= r_iofs; r_state <= S_RDWAIT;
                                r_iofs <= wr(32'(r_iofs) + 32'd1);
                                r_irem <= r_irem - OW'(1);
                            end
                        end
                        ACT_TRUNC: begin
                            r_occ <= '0; r_start <= '0; r_cnt <= '0; r_pend <= '0;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_st <= ST_IGN; r_state <= S_OUT;
                        end
                    endcase
                end
                // create: evict while it does not fit
                S_CRCHK: begin
                    if (r_occ != '0 && need32 > 32'(CAP)) begin
                        r_maddr <= r_start; r_k <= '0; r_hdr <= '0; r_rdp <= 1'b0;
                        r_state <= S_EVRD;
                    end else begin
                        r_newest <= wr(32'(r_start) + occ32);
                        if (need32 > 32'(CAP)) begin
                            r_fser <= r_fser + 32'd1; r_pend <= '0; r_st <= ST_DROP;
                            r_state <= S_OUT;
                        end else begin
                            r_cnt <= r_cnt + 11'd1;
                            r_hdr <= {20'd0, r_len}; r_k <= '0;
                            r_maddr <= wr(32'(r_start) + occ32 - 32'd1);
                            r_state <= S_CRWR;
                        end
                    end
                end
                // header write, four bytes big-endian (create and extend)
                S_CRWR, S_EXWR: begin
                    r_maddr <= r_maddr + AW'(1);
                    r_mwd <= r_hdr[31:24]; r_hdr <= {r_hdr[23:0], 8'd0};
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) begin
                        r_state <= S_OUT;
                        if (r_state == S_CRWR) begin
                            r_occ <= r_occ + OW'(r_len) + OW'(4);
                            r_wofs <= wr(32'(r_newest) + 32'd4);
                            r_pend <= OW'(r_len);
                        end else begin
                            if (r_pend == '0) r_wofs <= wr(32'(r_start) + occ32);
                            r_occ <= r_occ + OW'(r_len);
                            r_pend <= r_pend + OW'(r_len);
                        end
                    end
                end
                // header read shared by eviction, extend and iterator
                S_EVRD, S_EXRD, S_ITRD: begin
                    r_rdp <= 1'b1;
                    if (r_rdp) begin
                        r_hdr <= {r_hdr[23:0], r_mq};
                        r_k <= r_k + 3'd1;
                    end
                    r_maddr <= r_maddr + AW'(1);
                    if (r_rdp && r_k == 3'd3) begin
                        unique case (r_state)
                            S_EVRD: r_state <= S_EVCHK;
                            S_EXRD: r_state <= S_EXCHK;
                            default: r_state <= S_ITFIN;
                        endcase
                    end
                end
                S_EVCHK: begin
                    if (r_occ < OW'(4) || r_hdr > occ32 - 32'd4) begin
                        r_occ <= '0; r_start <= '0;
                    end else begin
                        r_occ <= OW'(occ32 - 32'd4 - r_hdr);
                        r_start <= (occ32 - 32'd4 - r_hdr == 32'd0) ? '0 :
                                   wr(32'(r_start) + 32'd4 + r_hdr);
                    end
                    if (r_cnt != '0) r_cnt <= r_cnt - 11'd1;
                    r_fser <= r_fser + 32'd1;
                    r_evc <= r_evc + 11'd1;
                    r_state <= (r_act == ACT_CREATE) ? S_CRCHK : S_EXCHK;
                end
                // extend: evict while it does not fit, then rewrite the newest header
                S_EXCHK: begin
                    if (r_occ != '0 && need32 > 32'(CAP)) begin
                        r_maddr <= r_start; r_k <= '0; r_rdp <= 1'b0;
                        r_state <= S_EVRD;
                    end else if (r_occ == '0) begin
                        r_newest <= '0; r_pend <= '0; r_st <= ST_DROP; r_state <= S_OUT;
                    end else begin
                        r_hdr <= r_xhdr;
                        r_k <= '0;
                        r_maddr <= r_newest - AW'(1);
                        r_state <= S_EXWR;
                    end
                end
                S_ITFIN: begin
                    r_iofs <= wr(32'(r_inext) + 32'd4);
                    r_irem <= OW'((r_hdr > CAPM4) ? CAPM4 : r_hdr);
                    r_inext <= wr(32'(r_inext) + 32'd4 + ((r_hdr > CAPM4) ? CAPM4 : r_hdr));
                    r_state <= S_OUT;
                end
                S_RDWAIT: begin
                    r_rdp <= 1'b1;
                    if (r_rdp) begin
                        r_rb <= r_mq; r_last <= (r_irem == '0); r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_axis_tvalid) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata <= {7'd0, 11'(r_evc), 12'(pay), r_cnt, r_last, r_rb,
                                         12'(r_irem), r_iser, r_st};
                    end else if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // extend: after header read, fold in the added length once
            if (r_state == S_EXRD && r_rdp && r_k == 3'd3)
                r_xhdr <= {r_hdr[23:0], r_mq} + 32'(r_len);
        end
    end
endmodule
`default_nettype wire
